// ----- rtl/core/vss_pkg.sv -----
package vss_pkg;

  // fixed formats
  localparam int GAIN_BITS  = 16;
  localparam int SQRT_STEPS = 32;
  localparam logic [16:0] SCALE_ONE = 17'h10000;

  // configuration register indexes
  localparam logic [2:0] REG_STEP_GAIN      = 3'd0;
  localparam logic [2:0] REG_STOP_THRESHOLD = 3'd1;
  localparam logic [2:0] REG_MAX_POS_STEP   = 3'd2;
  localparam logic [2:0] REG_MAX_LOOK_STEP  = 3'd3;
  localparam logic [2:0] REG_MAX_UP_STEP    = 3'd4;

  // vector selects
  localparam logic [1:0] VEC_POS  = 2'd0;
  localparam logic [1:0] VEC_LOOK = 2'd1;
  localparam logic [1:0] VEC_UP   = 2'd2;

  localparam logic [1:0] AXIS_LAST = 2'd2;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_SNAP,
    OP_VINIT,
    OP_ERR,
    OP_MUL_WANT,
    OP_CHECK,
    OP_SDIV_GO,
    OP_DIV_STEP,
    OP_SCALE,
    OP_FLOOR,
    OP_MUL_MOVE,
    OP_ADD,
    OP_MUL_SQ,
    OP_ACC,
    OP_SQRT_GO,
    OP_SQRT_STEP,
    OP_NDIV_GO,
    OP_NWR,
    OP_OUT
  } op_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DISPATCH,
    S_SNAP,
    S_VINIT,
    S_ERR,
    S_WANT,
    S_CHECK,
    S_SDIV_GO,
    S_SDIV,
    S_SCALE,
    S_FLOOR,
    S_MUL,
    S_ADD,
    S_SQ,
    S_ACC,
    S_SQRT_GO,
    S_SQRT,
    S_NCHK,
    S_NDIV_GO,
    S_NDIV,
    S_NWR,
    S_DONE
  } state_t;

  typedef struct packed {
    op_t        op;
    logic [1:0] vsel;
    logic [1:0] asel;
  } cmd_t;

  typedef struct packed {
    logic kind;
    logic need_div;
    logic vec_moved;
    logic norm_zero;
  } stat_t;

endpackage

// ----- rtl/core/vss_if.sv -----
interface vss_in_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic signed [31:0] target_pos_x;
  logic signed [31:0] target_pos_y;
  logic signed [31:0] target_pos_z;
  logic signed [31:0] target_look_x;
  logic signed [31:0] target_look_y;
  logic signed [31:0] target_look_z;
  logic signed [31:0] target_up_x;
  logic signed [31:0] target_up_y;
  logic signed [31:0] target_up_z;

  modport source (
    output valid, kind, target_pos_x, target_pos_y, target_pos_z,
           target_look_x, target_look_y, target_look_z,
           target_up_x, target_up_y, target_up_z,
    input  ready
  );
  modport sink (
    input  valid, kind, target_pos_x, target_pos_y, target_pos_z,
           target_look_x, target_look_y, target_look_z,
           target_up_x, target_up_y, target_up_z,
    output ready
  );
endinterface

interface vss_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic signed [31:0] look_x;
  logic signed [31:0] look_y;
  logic signed [31:0] look_z;
  logic signed [31:0] up_x;
  logic signed [31:0] up_y;
  logic signed [31:0] up_z;
  logic               camera_changed;

  modport source (
    output valid, pos_x, pos_y, pos_z, look_x, look_y, look_z,
           up_x, up_y, up_z, camera_changed,
    input  ready
  );
  modport sink (
    input  valid, pos_x, pos_y, pos_z, look_x, look_y, look_z,
           up_x, up_y, up_z, camera_changed,
    output ready
  );
endinterface

// ----- rtl/core/vss_datapath.sv -----
module vss_datapath #(
  parameter int FRACTION_BITS = 16,
  parameter int SCALE_FLOOR   = 66
) (
  input  logic               clk,
  input  logic               rst_n,
  input  vss_pkg::cmd_t      cmd,
  output vss_pkg::stat_t     stat,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [23:0]        cfg_wdata,
  input  logic               in_kind,
  input  logic signed [31:0] in_tgt [9],
  output logic signed [31:0] out_vec [9],
  output logic               out_changed
);

  localparam int DVW = 32 + FRACTION_BITS;

  // configuration registers
  logic [15:0] step_gain_r;
  logic [16:0] stop_thresh_r;
  logic [23:0] max_step_r [3];

  // vector state and targets
  logic signed [31:0] cur_r [9];
  logic signed [31:0] tgt_r [9];
  logic               kind_r;

  // per-vector work registers
  logic [32:0] mag_r;
  logic        neg_r;
  logic        pass_r;
  logic [32:0] want_r [3];
  logic        wneg_r [3];
  logic [16:0] scale_r;
  logic        moved_r;
  logic        changed_r;
  logic [63:0] mul_r;
  logic [63:0] sum_r;

  // shared divider and square root
  logic [DVW-1:0] quo_r;
  logic [33:0]    rem_r;
  logic [32:0]    den_r;
  logic [63:0]    sq_in_r;
  logic [33:0]    sq_rem_r;
  logic [31:0]    root_r;

  logic [3:0]         idx;
  logic signed [31:0] cur_sel;
  logic signed [31:0] tgt_sel;
  logic [32:0]        err;
  logic [32:0]        err_mag;
  logic [32:0]        w;
  logic [23:0]        lim;
  logic [31:0]        cur_abs;
  logic [32:0]        mul_a;
  logic [32:0]        mul_b;
  logic [65:0]        mul_p;
  logic [33:0]        rem_t;
  logic               div_bit;
  logic [33:0]        sq_t;
  logic [33:0]        sq_trial;
  logic [34:0]        add_sum;
  logic [34:0]        add_d;
  logic signed [31:0] add_sat;
  logic signed [31:0] nrm_sat;
  logic               snap_diff;

  // element select
  always_comb begin
    idx     = {1'b0, cmd.vsel, 1'b0} + {2'b00, cmd.vsel} + {2'b00, cmd.asel};
    cur_sel = cur_r[idx];
    tgt_sel = tgt_r[idx];
    err     = {tgt_sel[31], tgt_sel} - {cur_sel[31], cur_sel};
    err_mag = err[32] ? (~err + 33'd1) : err;
    w       = mul_r[48:16];
    cur_abs = cur_sel[31] ? (~cur_sel + 32'd1) : cur_sel;
    case (cmd.vsel)
      vss_pkg::VEC_POS:  lim = max_step_r[0];
      vss_pkg::VEC_LOOK: lim = max_step_r[1];
      vss_pkg::VEC_UP:   lim = max_step_r[2];
      default:           lim = max_step_r[0];
    endcase
  end

  // shared multiplier operands
  always_comb begin
    case (cmd.op)
      vss_pkg::OP_MUL_WANT: begin
        mul_a = mag_r;
        mul_b = {17'd0, step_gain_r};
      end
      vss_pkg::OP_MUL_MOVE: begin
        mul_a = want_r[cmd.asel];
        mul_b = {16'd0, scale_r};
      end
      vss_pkg::OP_MUL_SQ: begin
        mul_a = {1'b0, cur_abs};
        mul_b = {1'b0, cur_abs};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_p = {33'd0, mul_a} * {33'd0, mul_b};
  end

  // divider and square root steps
  always_comb begin
    rem_t    = {rem_r[32:0], quo_r[DVW-1]};
    div_bit  = (rem_t >= {1'b0, den_r});
    sq_t     = {sq_rem_r[31:0], sq_in_r[63:62]};
    sq_trial = {root_r, 2'b01};
  end

  // signed add of the move, saturated
  always_comb begin
    add_d   = wneg_r[cmd.asel] ? (~{2'b00, w} + 35'd1) : {2'b00, w};
    add_sum = {{3{cur_sel[31]}}, cur_sel} + add_d;
    if (add_sum[34:31] == 4'b0000 || add_sum[34:31] == 4'b1111) begin
      add_sat = add_sum[31:0];
    end else if (add_sum[34]) begin
      add_sat = 32'sh8000_0000;
    end else begin
      add_sat = 32'sh7fff_ffff;
    end
  end

  // normalized component, saturated
  always_comb begin
    if (cur_sel[31]) begin
      if (quo_r > DVW'(33'h0_8000_0000)) begin
        nrm_sat = 32'sh8000_0000;
      end else begin
        nrm_sat = ~quo_r[31:0] + 32'd1;
      end
    end else begin
      if (quo_r > DVW'(32'h7fff_ffff)) begin
        nrm_sat = 32'sh7fff_ffff;
      end else begin
        nrm_sat = quo_r[31:0];
      end
    end
  end

  always_comb begin
    snap_diff = 1'b0;
    for (int i = 0; i < 9; i++) begin
      if (cur_r[i] != tgt_r[i]) snap_diff = 1'b1;
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_gain_r   <= 16'd3277;
      stop_thresh_r <= 17'd66;
      max_step_r[0] <= 24'd131072;
      max_step_r[1] <= 24'd3932;
      max_step_r[2] <= 24'd6554;
    end else if (cfg_we) begin
      case (cfg_index)
        vss_pkg::REG_STEP_GAIN:      step_gain_r   <= cfg_wdata[15:0];
        vss_pkg::REG_STOP_THRESHOLD: stop_thresh_r <= cfg_wdata[16:0];
        vss_pkg::REG_MAX_POS_STEP:   max_step_r[0] <= cfg_wdata;
        vss_pkg::REG_MAX_LOOK_STEP:  max_step_r[1] <= cfg_wdata;
        vss_pkg::REG_MAX_UP_STEP:    max_step_r[2] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // vector state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 9; i++) cur_r[i] <= '0;
    end else begin
      case (cmd.op)
        vss_pkg::OP_SNAP: begin
          for (int i = 0; i < 9; i++) cur_r[i] <= tgt_r[i];
        end
        vss_pkg::OP_CHECK: begin
          if (pass_r && w == 33'd0) cur_r[idx] <= tgt_sel;
        end
        vss_pkg::OP_ADD: begin
          if (want_r[cmd.asel] != 33'd0) cur_r[idx] <= add_sat;
        end
        vss_pkg::OP_NWR: cur_r[idx] <= nrm_sat;
        default: ;
      endcase
    end
  end

  // status flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r    <= 1'b0;
      moved_r   <= 1'b0;
      changed_r <= 1'b0;
    end else begin
      case (cmd.op)
        vss_pkg::OP_CAPTURE: begin
          kind_r    <= in_kind;
          changed_r <= 1'b0;
        end
        vss_pkg::OP_SNAP:  changed_r <= snap_diff;
        vss_pkg::OP_VINIT: moved_r   <= 1'b0;
        vss_pkg::OP_CHECK: begin
          if (pass_r && w != 33'd0) begin
            moved_r   <= 1'b1;
            changed_r <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // arithmetic work registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      vss_pkg::OP_CAPTURE: begin
        for (int i = 0; i < 9; i++) tgt_r[i] <= in_tgt[i];
      end
      vss_pkg::OP_VINIT: begin
        scale_r <= vss_pkg::SCALE_ONE;
        sum_r   <= '0;
      end
      vss_pkg::OP_ERR: begin
        mag_r  <= err_mag;
        neg_r  <= err[32];
        pass_r <= (err_mag > {16'd0, stop_thresh_r});
      end
      vss_pkg::OP_MUL_WANT, vss_pkg::OP_MUL_MOVE, vss_pkg::OP_MUL_SQ: begin
        mul_r <= mul_p[63:0];
      end
      vss_pkg::OP_CHECK: begin
        want_r[cmd.asel] <= (pass_r) ? w : 33'd0;
        wneg_r[cmd.asel] <= neg_r;
      end
      vss_pkg::OP_SDIV_GO: begin
        quo_r <= DVW'({lim, 16'h0000});
        den_r <= w;
        rem_r <= '0;
      end
      vss_pkg::OP_NDIV_GO: begin
        quo_r <= DVW'(cur_abs) << FRACTION_BITS;
        den_r <= {1'b0, root_r};
        rem_r <= '0;
      end
      vss_pkg::OP_DIV_STEP: begin
        rem_r <= div_bit ? (rem_t - {1'b0, den_r}) : rem_t;
        quo_r <= {quo_r[DVW-2:0], div_bit};
      end
      vss_pkg::OP_SCALE: begin
        if (quo_r[16:0] < scale_r) scale_r <= quo_r[16:0];
      end
      vss_pkg::OP_FLOOR: begin
        if (scale_r < 17'(SCALE_FLOOR)) scale_r <= 17'(SCALE_FLOOR);
      end
      vss_pkg::OP_ACC: sum_r <= sum_r + mul_r;
      vss_pkg::OP_SQRT_GO: begin
        sq_in_r  <= sum_r;
        sq_rem_r <= '0;
        root_r   <= '0;
      end
      vss_pkg::OP_SQRT_STEP: begin
        sq_in_r <= {sq_in_r[61:0], 2'b00};
        if (sq_t >= sq_trial) begin
          sq_rem_r <= sq_t - sq_trial;
          root_r   <= {root_r[30:0], 1'b1};
        end else begin
          sq_rem_r <= sq_t;
          root_r   <= {root_r[30:0], 1'b0};
        end
      end
      default: ;
    endcase
  end

  // output holding register
  always_ff @(posedge clk) begin
    if (cmd.op == vss_pkg::OP_OUT) begin
      for (int i = 0; i < 9; i++) out_vec[i] <= cur_r[i];
      out_changed <= changed_r;
    end
  end

  always_comb begin
    stat.kind      = kind_r;
    stat.need_div  = pass_r && (w != 33'd0) && (w > {9'd0, lim});
    stat.vec_moved = moved_r;
    stat.norm_zero = (root_r == 32'd0);
  end

endmodule

// ----- rtl/core/vss_ctrl.sv -----
module vss_ctrl #(
  parameter int FRACTION_BITS = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  vss_pkg::stat_t stat,
  output vss_pkg::cmd_t  cmd
);

  localparam int DVW = 32 + FRACTION_BITS;
  localparam int CW  = $clog2(DVW + 1);

  vss_pkg::state_t state_r, state_nxt;
  logic [1:0]      v_r, v_nxt;
  logic [1:0]      a_r, a_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            oval_r, oval_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= vss_pkg::S_IDLE;
      v_r     <= '0;
      a_r     <= '0;
      cnt_r   <= '0;
      oval_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      v_r     <= v_nxt;
      a_r     <= a_nxt;
      cnt_r   <= cnt_nxt;
      oval_r  <= oval_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    v_nxt     = v_r;
    a_nxt     = a_r;
    cnt_nxt   = cnt_r;
    oval_nxt  = oval_r && !out_ready;
    cmd.op    = vss_pkg::OP_NONE;
    cmd.vsel  = v_r;
    cmd.asel  = a_r;
    in_ready  = 1'b0;
    case (state_r)
      vss_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op    = vss_pkg::OP_CAPTURE;
          state_nxt = vss_pkg::S_DISPATCH;
        end
      end
      vss_pkg::S_DISPATCH: begin
        v_nxt     = vss_pkg::VEC_POS;
        state_nxt = stat.kind ? vss_pkg::S_SNAP : vss_pkg::S_VINIT;
      end
      vss_pkg::S_SNAP: begin
        cmd.op    = vss_pkg::OP_SNAP;
        state_nxt = vss_pkg::S_DONE;
      end
      vss_pkg::S_VINIT: begin
        cmd.op    = vss_pkg::OP_VINIT;
        a_nxt     = '0;
        state_nxt = vss_pkg::S_ERR;
      end
      vss_pkg::S_ERR: begin
        cmd.op    = vss_pkg::OP_ERR;
        state_nxt = vss_pkg::S_WANT;
      end
      vss_pkg::S_WANT: begin
        cmd.op    = vss_pkg::OP_MUL_WANT;
        state_nxt = vss_pkg::S_CHECK;
      end
      vss_pkg::S_CHECK: begin
        cmd.op = vss_pkg::OP_CHECK;
        if (stat.need_div) begin
          state_nxt = vss_pkg::S_SDIV_GO;
        end else if (a_r == vss_pkg::AXIS_LAST) begin
          state_nxt = vss_pkg::S_FLOOR;
        end else begin
          a_nxt     = a_r + 2'd1;
          state_nxt = vss_pkg::S_ERR;
        end
      end
      vss_pkg::S_SDIV_GO: begin
        cmd.op    = vss_pkg::OP_SDIV_GO;
        cnt_nxt   = CW'(DVW);
        state_nxt = vss_pkg::S_SDIV;
      end
      vss_pkg::S_SDIV: begin
        cmd.op  = vss_pkg::OP_DIV_STEP;
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == CW'(1)) state_nxt = vss_pkg::S_SCALE;
      end
      vss_pkg::S_SCALE: begin
        cmd.op = vss_pkg::OP_SCALE;
        if (a_r == vss_pkg::AXIS_LAST) begin
          state_nxt = vss_pkg::S_FLOOR;
        end else begin
          a_nxt     = a_r + 2'd1;
          state_nxt = vss_pkg::S_ERR;
        end
      end
      vss_pkg::S_FLOOR: begin
        cmd.op    = vss_pkg::OP_FLOOR;
        a_nxt     = '0;
        state_nxt = vss_pkg::S_MUL;
      end
      vss_pkg::S_MUL: begin
        cmd.op    = vss_pkg::OP_MUL_MOVE;
        state_nxt = vss_pkg::S_ADD;
      end
      vss_pkg::S_ADD: begin
        cmd.op = vss_pkg::OP_ADD;
        if (a_r == vss_pkg::AXIS_LAST) begin
          a_nxt = '0;
          if (v_r != vss_pkg::VEC_POS && stat.vec_moved) begin
            state_nxt = vss_pkg::S_SQ;
          end else if (v_r == vss_pkg::VEC_UP) begin
            state_nxt = vss_pkg::S_DONE;
          end else begin
            v_nxt     = v_r + 2'd1;
            state_nxt = vss_pkg::S_VINIT;
          end
        end else begin
          a_nxt     = a_r + 2'd1;
          state_nxt = vss_pkg::S_MUL;
        end
      end
      vss_pkg::S_SQ: begin
        cmd.op    = vss_pkg::OP_MUL_SQ;
        state_nxt = vss_pkg::S_ACC;
      end
      vss_pkg::S_ACC: begin
        cmd.op = vss_pkg::OP_ACC;
        if (a_r == vss_pkg::AXIS_LAST) begin
          state_nxt = vss_pkg::S_SQRT_GO;
        end else begin
          a_nxt     = a_r + 2'd1;
          state_nxt = vss_pkg::S_SQ;
        end
      end
      vss_pkg::S_SQRT_GO: begin
        cmd.op    = vss_pkg::OP_SQRT_GO;
        cnt_nxt   = CW'(vss_pkg::SQRT_STEPS);
        state_nxt = vss_pkg::S_SQRT;
      end
      vss_pkg::S_SQRT: begin
        cmd.op  = vss_pkg::OP_SQRT_STEP;
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == CW'(1)) state_nxt = vss_pkg::S_NCHK;
      end
      vss_pkg::S_NCHK: begin
        a_nxt = '0;
        if (!stat.norm_zero) begin
          state_nxt = vss_pkg::S_NDIV_GO;
        end else if (v_r == vss_pkg::VEC_UP) begin
          state_nxt = vss_pkg::S_DONE;
        end else begin
          v_nxt     = v_r + 2'd1;
          state_nxt = vss_pkg::S_VINIT;
        end
      end
      vss_pkg::S_NDIV_GO: begin
        cmd.op    = vss_pkg::OP_NDIV_GO;
        cnt_nxt   = CW'(DVW);
        state_nxt = vss_pkg::S_NDIV;
      end
      vss_pkg::S_NDIV: begin
        cmd.op  = vss_pkg::OP_DIV_STEP;
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == CW'(1)) state_nxt = vss_pkg::S_NWR;
      end
      vss_pkg::S_NWR: begin
        cmd.op = vss_pkg::OP_NWR;
        if (a_r != vss_pkg::AXIS_LAST) begin
          a_nxt     = a_r + 2'd1;
          state_nxt = vss_pkg::S_NDIV_GO;
        end else if (v_r == vss_pkg::VEC_UP) begin
          state_nxt = vss_pkg::S_DONE;
        end else begin
          v_nxt     = v_r + 2'd1;
          state_nxt = vss_pkg::S_VINIT;
        end
      end
      vss_pkg::S_DONE: begin
        // load the output register once the previous result is gone
        if (!oval_r || out_ready) begin
          cmd.op    = vss_pkg::OP_OUT;
          oval_nxt  = 1'b1;
          state_nxt = vss_pkg::S_IDLE;
        end
      end
      default: state_nxt = vss_pkg::S_IDLE;
    endcase
    out_valid = oval_r;
  end

endmodule

// ----- rtl/core/vector_slew_smoother_unit.sv -----
// channel   direction  transfer when      payload
// in_chan   sink       valid && ready     kind, nine Q16.16 target axes
// out_chan  source     valid && ready     nine Q16.16 state axes, camera_changed
// cfg_*     write      cfg_we             cfg_index selects register, cfg_wdata
//
// load item: the targets are captured and copied into the state. step item: per
// vector, error, wanted move and check for each axis, a division for each axis
// over its limit, then the scaled moves, plus square root and division for a moved
// look or up vector; one shared multiplier and one bit-serial divider serve these.
// reset is synchronous, active low, and restores the register defaults and a zero state.
// a result waits in the output register while the next item is taken and worked on.
module vector_slew_smoother_unit #(
  parameter int FRACTION_BITS = 16,
  parameter int SCALE_FLOOR   = 66
) (
  input  logic        clk,
  input  logic        rst_n,
  vss_in_if.sink      in_chan,
  vss_out_if.source   out_chan,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_wdata
);

  vss_pkg::cmd_t      cmd;
  vss_pkg::stat_t     stat;
  logic signed [31:0] in_tgt [9];
  logic signed [31:0] out_vec [9];
  logic               out_changed;

  // target vector gather
  assign in_tgt[0] = in_chan.target_pos_x;
  assign in_tgt[1] = in_chan.target_pos_y;
  assign in_tgt[2] = in_chan.target_pos_z;
  assign in_tgt[3] = in_chan.target_look_x;
  assign in_tgt[4] = in_chan.target_look_y;
  assign in_tgt[5] = in_chan.target_look_z;
  assign in_tgt[6] = in_chan.target_up_x;
  assign in_tgt[7] = in_chan.target_up_y;
  assign in_tgt[8] = in_chan.target_up_z;

  vss_ctrl #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .out_valid(out_chan.valid),
    .out_ready(out_chan.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  vss_datapath #(
    .FRACTION_BITS(FRACTION_BITS),
    .SCALE_FLOOR  (SCALE_FLOOR)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_kind    (in_chan.kind),
    .in_tgt     (in_tgt),
    .out_vec    (out_vec),
    .out_changed(out_changed)
  );

  // result fields
  assign out_chan.pos_x          = out_vec[0];
  assign out_chan.pos_y          = out_vec[1];
  assign out_chan.pos_z          = out_vec[2];
  assign out_chan.look_x         = out_vec[3];
  assign out_chan.look_y         = out_vec[4];
  assign out_chan.look_z         = out_vec[5];
  assign out_chan.up_x           = out_vec[6];
  assign out_chan.up_y           = out_vec[7];
  assign out_chan.up_z           = out_vec[8];
  assign out_chan.camera_changed = out_changed;

endmodule

// ----- rtl/core/vss_checker.sv -----
module vss_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_pos_x
);

  // stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // stalled result payload holds
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_pos_x))
    else $error("result payload changed while stalled");

  // one item at a time: busy right after an input transfer
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an item is in work");

  // a new result means the block is free again
  a_free: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> in_ready)
    else $error("result posted while still busy");

endmodule

bind vector_slew_smoother_unit vss_checker u_vss_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_chan.valid),
  .in_ready (in_chan.ready),
  .out_valid(out_chan.valid),
  .out_ready(out_chan.ready),
  .out_pos_x(out_chan.pos_x)
);

// ----- verif/vss_checker.sv -----
`timescale 1ns / 100ps

module vss_tb_checker (
  input  logic        clk,
  input  logic        rst_n,
  vss_in_if.sink      in_mon,
  vss_out_if.sink     out_mon,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_wdata,
  output int          fail_count,
  output int          pending_count,
  output int          result_count,
  output int          changed_count
);

  localparam int FRAC   = 16;
  localparam int SFLOOR = 66;

  typedef struct {
    logic signed [31:0] v [9];
    logic               changed;
  } camera_t;

  // predictor state and registers
  logic [15:0]  gain_q;
  logic [16:0]  thresh_q;
  logic [23:0]  limit_q [3];
  longint       cam_q [3][3];
  camera_t      expected_cams [$];

  function automatic longint clamp32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic longint unsigned root64(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // scale one vector to unit length
  task automatic make_unit(int vi);
    longint unsigned sq, nrm, m, q;
    sq = 0;
    for (int a = 0; a < 3; a++) begin
      m = cam_q[vi][a] < 0 ? -cam_q[vi][a] : cam_q[vi][a];
      sq += m * m;
    end
    nrm = root64(sq);
    if (nrm != 0) begin
      for (int a = 0; a < 3; a++) begin
        m = cam_q[vi][a] < 0 ? -cam_q[vi][a] : cam_q[vi][a];
        q = (m << FRAC) / nrm;
        cam_q[vi][a] = clamp32(cam_q[vi][a] < 0 ? -longint'(q) : longint'(q));
      end
    end
  endtask

  // ease one vector toward its target, returns whether any axis wanted a move
  function automatic bit ease_vector(int vi, longint tgt [3]);
    longint unsigned want [3], mag, w, s, sc, d;
    bit neg [3];
    bit moved;
    longint err;
    sc = 65536;
    moved = 0;
    for (int a = 0; a < 3; a++) begin
      err = tgt[a] - cam_q[vi][a];
      mag = err < 0 ? -err : err;
      want[a] = 0;
      neg[a] = err < 0;
      if (mag > thresh_q) begin
        w = (mag * gain_q) >> vss_pkg::GAIN_BITS;
        if (w == 0) begin
          cam_q[vi][a] = tgt[a];
        end else begin
          want[a] = w;
          moved = 1;
          if (w > limit_q[vi]) begin
            s = (longint'(limit_q[vi]) << 16) / w;
            if (s < sc) sc = s;
          end
        end
      end
    end
    if (sc < SFLOOR) sc = SFLOOR;
    for (int a = 0; a < 3; a++)
      if (want[a] != 0) begin
        d = (want[a] * sc) >> 16;
        cam_q[vi][a] = clamp32(cam_q[vi][a] + (neg[a] ? -longint'(d) : longint'(d)));
      end
    return moved;
  endfunction

  task automatic predict_camera(logic kind, logic signed [31:0] tv [9]);
    longint tgt [3][3];
    longint one [3];
    bit chg, mp, ml, mu;
    camera_t c;
    chg = 0;
    for (int i = 0; i < 9; i++) tgt[i / 3][i % 3] = tv[i];
    if (kind) begin
      for (int i = 0; i < 9; i++) begin
        if (cam_q[i / 3][i % 3] != tgt[i / 3][i % 3]) chg = 1;
        cam_q[i / 3][i % 3] = tgt[i / 3][i % 3];
      end
    end else begin
      one = tgt[0]; mp = ease_vector(0, one);
      one = tgt[1]; ml = ease_vector(1, one);
      one = tgt[2]; mu = ease_vector(2, one);
      chg = mp | ml | mu;
      if (ml) make_unit(1);
      if (mu) make_unit(2);
    end
    for (int i = 0; i < 9; i++) c.v[i] = cam_q[i / 3][i % 3];
    c.changed = chg;
    expected_cams.push_back(c);
  endtask

  // watch configuration writes, input and result transfers
  always @(posedge clk) begin
    logic signed [31:0] tv [9];
    logic signed [31:0] got [9];
    camera_t e;
    int nerr;
    nerr = 0;
    if (!rst_n) begin
      gain_q <= 16'd3277;
      thresh_q <= 17'd66;
      limit_q[0] <= 24'd131072;
      limit_q[1] <= 24'd3932;
      limit_q[2] <= 24'd6554;
      for (int i = 0; i < 9; i++) cam_q[i / 3][i % 3] = 0;
      expected_cams.delete();
      fail_count <= 0;
      result_count <= 0;
      changed_count <= 0;
      pending_count <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          vss_pkg::REG_STEP_GAIN:      gain_q <= cfg_wdata[15:0];
          vss_pkg::REG_STOP_THRESHOLD: thresh_q <= cfg_wdata[16:0];
          vss_pkg::REG_MAX_POS_STEP:   limit_q[0] <= cfg_wdata;
          vss_pkg::REG_MAX_LOOK_STEP:  limit_q[1] <= cfg_wdata;
          vss_pkg::REG_MAX_UP_STEP:    limit_q[2] <= cfg_wdata;
          default: ;
        endcase
      end
      if (out_mon.valid && out_mon.ready) begin
        got = '{out_mon.pos_x, out_mon.pos_y, out_mon.pos_z, out_mon.look_x,
                out_mon.look_y, out_mon.look_z, out_mon.up_x, out_mon.up_y,
                out_mon.up_z};
        result_count <= result_count + 1;
        if (expected_cams.size() == 0) begin
          $error("result transfer with nothing expected");
          nerr++;
        end else begin
          e = expected_cams.pop_front();
          if (e.changed) changed_count <= changed_count + 1;
          for (int i = 0; i < 9; i++)
            if (got[i] !== e.v[i]) begin
              $error("field %s expected %0d actual %0d",
                     i == 0 ? "pos_x" : i == 1 ? "pos_y" : i == 2 ? "pos_z" :
                     i == 3 ? "look_x" : i == 4 ? "look_y" : i == 5 ? "look_z" :
                     i == 6 ? "up_x" : i == 7 ? "up_y" : "up_z", e.v[i], got[i]);
              nerr++;
            end
          if (out_mon.camera_changed !== e.changed) begin
            $error("field camera_changed expected %0d actual %0d",
                   e.changed, out_mon.camera_changed);
            nerr++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        tv = '{in_mon.target_pos_x, in_mon.target_pos_y, in_mon.target_pos_z,
               in_mon.target_look_x, in_mon.target_look_y, in_mon.target_look_z,
               in_mon.target_up_x, in_mon.target_up_y, in_mon.target_up_z};
        predict_camera(in_mon.kind, tv);
      end
      if (nerr != 0) fail_count <= fail_count + nerr;
      pending_count <= expected_cams.size();
    end
  end
endmodule

// ----- verif/vector_slew_smoother_unit_tb.sv -----
`timescale 1ns / 100ps

module vector_slew_smoother_unit_tb;

  localparam int CYCLE_LIMIT = 10000000;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [23:0] cfg_wdata;
  int          fail_count, pending_count, result_count, changed_count;
  int          send_idle_pct, recv_stall_pct;
  int          hold_off_cycles;
  int          cycle_count;
  int          item_count;

  vss_in_if  in_chan ();
  vss_out_if out_chan ();

  vector_slew_smoother_unit dut (
    .clk(clk), .rst_n(rst_n), .in_chan(in_chan), .out_chan(out_chan),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  vss_tb_checker checker_i (
    .clk(clk), .rst_n(rst_n), .in_mon(in_chan), .out_mon(out_chan),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .fail_count(fail_count), .pending_count(pending_count),
    .result_count(result_count), .changed_count(changed_count)
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // receiver: random stalls plus an occasional long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else if (hold_off_cycles > 0) begin
      out_chan.ready <= 1'b0;
      hold_off_cycles <= hold_off_cycles - 1;
    end else begin
      out_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic logic signed [31:0] pick_axis(int style);
    case (style)
      0: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
      1: return $signed($urandom());
      2: return $signed($urandom_range(131072)) - 32'sd65536;
      default: return $signed($urandom_range(1 << 22)) - 32'sd2097152;
    endcase
  endfunction

  // offer one item and hold it until the transfer
  task automatic send_item(logic kind, logic signed [31:0] tv [9]);
    while ($urandom_range(99) < send_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.kind <= kind;
    in_chan.target_pos_x <= tv[0];
    in_chan.target_pos_y <= tv[1];
    in_chan.target_pos_z <= tv[2];
    in_chan.target_look_x <= tv[3];
    in_chan.target_look_y <= tv[4];
    in_chan.target_look_z <= tv[5];
    in_chan.target_up_x <= tv[6];
    in_chan.target_up_y <= tv[7];
    in_chan.target_up_z <= tv[8];
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    item_count++;
  endtask

  task automatic send_random(int n);
    logic signed [31:0] tv [9];
    int style;
    for (int k = 0; k < n; k++) begin
      style = $urandom_range(9);
      for (int i = 0; i < 9; i++)
        tv[i] = pick_axis(style == 0 ? $urandom_range(3) : style < 4 ? 2 : style < 7 ? 3 : 1);
      send_item($urandom_range(7) == 0, tv);
    end
  endtask

  // stop offering and wait for every expected result
  task automatic drain();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [23:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_all(logic [23:0] g, logic [23:0] t, logic [23:0] p,
                         logic [23:0] l, logic [23:0] u);
    write_reg(vss_pkg::REG_STEP_GAIN, g);
    write_reg(vss_pkg::REG_STOP_THRESHOLD, t);
    write_reg(vss_pkg::REG_MAX_POS_STEP, p);
    write_reg(vss_pkg::REG_MAX_LOOK_STEP, l);
    write_reg(vss_pkg::REG_MAX_UP_STEP, u);
  endtask

  task automatic set_idle(int s, int r);
    send_idle_pct = s;
    recv_stall_pct = r;
  endtask

  initial begin
    logic signed [31:0] tv [9];
    rst_n = 0;
    cfg_we = 0; cfg_index = '0; cfg_wdata = '0;
    hold_off_cycles = 0; cycle_count = 0; item_count = 0;
    send_idle_pct = 0; recv_stall_pct = 0;
    in_chan.valid = 0; in_chan.kind = 0;
    in_chan.target_pos_x = 0; in_chan.target_pos_y = 0; in_chan.target_pos_z = 0;
    in_chan.target_look_x = 0; in_chan.target_look_y = 0; in_chan.target_look_z = 0;
    in_chan.target_up_x = 0; in_chan.target_up_y = 0; in_chan.target_up_z = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: steps at reset defaults, zero vectors stay unnormalized
    tv = '{default: 32'sd0};
    send_item(1'b0, tv);
    tv = '{32'sd65536, -32'sd65536, 32'sd10, 32'sd65536, 32'sd0, 32'sd0,
           32'sd0, 32'sd65536, 32'sd0};
    send_item(1'b0, tv);
    send_item(1'b0, tv);
    // load extremes, then same load again for no change
    tv = '{32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh80000000,
           32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sd0};
    send_item(1'b1, tv);
    send_item(1'b1, tv);
    // step across full range at largest gain and limits
    tv = '{32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
           32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sd0};
    drain();
    set_all(24'd65535, 24'd0, 24'hffffff, 24'hffffff, 24'hffffff);
    send_item(1'b0, tv);
    send_item(1'b0, tv);
    // tiny gain: wanted move truncates to zero, axis jumps to target
    drain();
    set_all(24'd1, 24'd0, 24'd0, 24'd0, 24'd0);
    tv = '{32'sd100, -32'sd100, 32'sd5, 32'sd7, 32'sd0, -32'sd3, 32'sd1, 32'sd2, 32'sd3};
    send_item(1'b1, '{default: 32'sd0});
    send_item(1'b0, tv);
    // zero limits force the scale floor
    tv = '{32'sh7fffffff, 32'sd0, -32'sd99999, 32'sd0, 32'sh7fffffff, 32'sd0,
           -32'sd65536, 32'sd0, 32'sd0};
    send_item(1'b0, tv);
    drain();
    set_all(24'd32768, 24'd65536, 24'd0, 24'd0, 24'd0);
    send_item(1'b0, tv);
    send_item(1'b0, tv);
    drain();

    // random phases over several register settings
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: set_all(24'd3277, 24'd66, 24'd131072, 24'd3932, 24'd6554);
        1: set_all(24'($urandom_range(65535)), 24'($urandom_range(65536)),
                   24'($urandom_range(24'hffffff)), 24'($urandom_range(24'hffffff)),
                   24'($urandom_range(24'hffffff)));
        2: set_all(24'd65535, 24'd65536, 24'hffffff, 24'd1, 24'd0);
        3: set_all(24'd0, 24'd0, 24'd0, 24'hffffff, 24'd100);
        default: set_all(24'($urandom_range(65535)), 24'($urandom_range(200)),
                         24'($urandom_range(1 << 20)), 24'($urandom_range(8000)),
                         24'($urandom_range(8000)));
      endcase
      case (ph % 4)
        0: set_idle(0, 0);
        1: set_idle(83, 0);
        2: set_idle(0, 83);
        default: set_idle(9, 9);
      endcase
      if (ph == 5) begin
        set_idle(0, 0);
        hold_off_cycles <= 3000;
      end
      send_random(160);
      // sender pauses until all results are back
      drain();
    end

    $display("run covered %0d input items, %0d results, %0d with camera moved",
             item_count, result_count, changed_count);
    if (fail_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end
endmodule

// ----- vector_slew_smoother_unit.f -----
rtl/core/vss_pkg.sv
rtl/core/vss_if.sv
rtl/core/vss_datapath.sv
rtl/core/vss_ctrl.sv
rtl/core/vector_slew_smoother_unit.sv
rtl/core/vss_checker.sv
verif/vss_checker.sv
verif/vector_slew_smoother_unit_tb.sv
